### design/fit_pkg.sv
`default_nettype none
package fit_pkg;
    localparam int TABLE_ENTRIES_DEF = 256;
    localparam int ADDR_BITS_DEF     = 48;
    localparam int SIZE_BITS_DEF     = 32;

    localparam logic [1:0] ACT_RECORD  = 2'd0;
    localparam logic [1:0] ACT_EXACT   = 2'd1;
    localparam logic [1:0] ACT_CONTAIN = 2'd2;
    localparam logic [1:0] ACT_CLEAR   = 2'd3;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_IGNORED  = 3'd1;
    localparam logic [2:0] ST_DUP_SAME = 3'd2;
    localparam logic [2:0] ST_REJECTED = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;
    localparam logic [2:0] ST_HIT      = 3'd5;
    localparam logic [2:0] ST_MISS     = 3'd6;
    localparam logic [2:0] ST_CLEARED  = 3'd7;
endpackage
`default_nettype wire

### design/forwarding_interval_table.sv
`default_nettype none
// Forwarding table for a copying collector, kept in a row of TABLE_ENTRIES cells, one entry
// each. Every accepted beat sends a search token down the row, one cell per cycle, which
// gathers the exact-key match, the greatest key at or below the address and the first free
// slot; the result is formed after the token leaves the last cell. One beat is taken at a
// time: the next beat can be accepted as soon as the result of the last one is presented,
// and a result held back by the sink holds the following result back. Inserts and clears
// are applied to the cells as the result is presented. The result register lets the next
// beat be accepted while a result still waits.
module forwarding_interval_table #(
    parameter int TABLE_ENTRIES = fit_pkg::TABLE_ENTRIES_DEF,
    parameter int ADDR_BITS     = fit_pkg::ADDR_BITS_DEF,
    parameter int SIZE_BITS     = fit_pkg::SIZE_BITS_DEF,
    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
    localparam int CW = $clog2(TABLE_ENTRIES + 1)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [1:0]           i_action,
    input  wire logic [ADDR_BITS-1:0] i_source_address,
    input  wire logic [ADDR_BITS-1:0] i_target_address,
    input  wire logic [SIZE_BITS-1:0] i_object_size,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [2:0]                o_status,
    output logic                      o_hit,
    output logic [ADDR_BITS-1:0]      o_result_address,
    output logic [SIZE_BITS-1:0]      o_offset_out,
    output logic [CW-1:0]             o_entry_count
);
    logic                 t_act   [0:TABLE_ENTRIES];
    logic                 t_found [0:TABLE_ENTRIES];
    logic [ADDR_BITS-1:0] t_ftgt  [0:TABLE_ENTRIES];
    logic                 t_bv    [0:TABLE_ENTRIES];
    logic [ADDR_BITS-1:0] t_bk    [0:TABLE_ENTRIES];
    logic [ADDR_BITS-1:0] t_btgt  [0:TABLE_ENTRIES];
    logic [SIZE_BITS-1:0] t_bsz   [0:TABLE_ENTRIES];
    logic                 t_fs    [0:TABLE_ENTRIES];
    logic [IW-1:0]        t_fidx  [0:TABLE_ENTRIES];
    logic                 w_launch;
    logic [ADDR_BITS-1:0] w_src;
    logic [ADDR_BITS-1:0] w_wr_tgt;
    logic [SIZE_BITS-1:0] w_wr_size;
    logic                 w_we;
    logic [IW-1:0]        w_wr_idx;
    logic                 w_clear;

    assign t_act[0]   = w_launch;
    assign t_found[0] = 1'b0;
    assign t_ftgt[0]  = '0;
    assign t_bv[0]    = 1'b0;
    assign t_bk[0]    = '0;
    assign t_btgt[0]  = '0;
    assign t_bsz[0]   = '0;
    assign t_fs[0]    = 1'b0;
    assign t_fidx[0]  = '0;

    fit_ctrl #(
        .TABLE_ENTRIES(TABLE_ENTRIES), .ADDR_BITS(ADDR_BITS), .SIZE_BITS(SIZE_BITS),
        .IW(IW), .CW(CW)
    ) u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_action, .i_source_address,
        .i_target_address, .i_object_size, .o_valid, .i_ready, .o_status, .o_hit,
        .o_result_address, .o_offset_out, .o_entry_count,
        .o_launch(w_launch), .o_src(w_src), .o_wr_tgt(w_wr_tgt), .o_wr_size(w_wr_size),
        .o_we(w_we), .o_wr_idx(w_wr_idx), .o_clear(w_clear),
        .i_act(t_act[TABLE_ENTRIES]), .i_found(t_found[TABLE_ENTRIES]),
        .i_ftgt(t_ftgt[TABLE_ENTRIES]), .i_bv(t_bv[TABLE_ENTRIES]),
        .i_bk(t_bk[TABLE_ENTRIES]), .i_btgt(t_btgt[TABLE_ENTRIES]),
        .i_bsz(t_bsz[TABLE_ENTRIES]), .i_fs(t_fs[TABLE_ENTRIES]),
        .i_fidx(t_fidx[TABLE_ENTRIES])
    );

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        fit_cell #(
            .ADDR_BITS(ADDR_BITS), .SIZE_BITS(SIZE_BITS), .IW(IW), .IDX(g)
        ) u_cell (
            .i_clk, .i_rst_n, .i_src(w_src), .i_we(w_we), .i_wr_idx(w_wr_idx),
            .i_wr_tgt(w_wr_tgt), .i_wr_size(w_wr_size), .i_clear(w_clear),
            .i_act(t_act[g]), .i_found(t_found[g]), .i_ftgt(t_ftgt[g]),
            .i_bv(t_bv[g]), .i_bk(t_bk[g]), .i_btgt(t_btgt[g]), .i_bsz(t_bsz[g]),
            .i_fs(t_fs[g]), .i_fidx(t_fidx[g]),
            .o_act(t_act[g+1]), .o_found(t_found[g+1]), .o_ftgt(t_ftgt[g+1]),
            .o_bv(t_bv[g+1]), .o_bk(t_bk[g+1]), .o_btgt(t_btgt[g+1]),
            .o_bsz(t_bsz[g+1]), .o_fs(t_fs[g+1]), .o_fidx(t_fidx[g+1])
        );
    end
endmodule
`default_nettype wire

### design/fit_cell.sv
`default_nettype none
module fit_cell #(
    parameter int ADDR_BITS = fit_pkg::ADDR_BITS_DEF,
    parameter int SIZE_BITS = fit_pkg::SIZE_BITS_DEF,
    parameter int IW        = 8,
    parameter int IDX       = 0
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [ADDR_BITS-1:0] i_src,
    input  wire logic                 i_we,
    input  wire logic [IW-1:0]        i_wr_idx,
    input  wire logic [ADDR_BITS-1:0] i_wr_tgt,
    input  wire logic [SIZE_BITS-1:0] i_wr_size,
    input  wire logic                 i_clear,
    input  wire logic                 i_act,
    input  wire logic                 i_found,
    input  wire logic [ADDR_BITS-1:0] i_ftgt,
    input  wire logic                 i_bv,
    input  wire logic [ADDR_BITS-1:0] i_bk,
    input  wire logic [ADDR_BITS-1:0] i_btgt,
    input  wire logic [SIZE_BITS-1:0] i_bsz,
    input  wire logic                 i_fs,
    input  wire logic [IW-1:0]        i_fidx,
    output logic                      o_act,
    output logic                      o_found,
    output logic [ADDR_BITS-1:0]      o_ftgt,
    output logic                      o_bv,
    output logic [ADDR_BITS-1:0]      o_bk,
    output logic [ADDR_BITS-1:0]      o_btgt,
    output logic [SIZE_BITS-1:0]      o_bsz,
    output logic                      o_fs,
    output logic [IW-1:0]             o_fidx
);
    logic                 r_valid;
    logic [ADDR_BITS-1:0] r_key;
    logic [ADDR_BITS-1:0] r_tgt;
    logic [SIZE_BITS-1:0] r_size;
    logic                 w_match;
    logic                 w_floor;
    logic                 w_free;

    assign w_match = r_valid && (r_key == i_src);
    assign w_floor = r_valid && (r_key <= i_src) && (!i_bv || (r_key > i_bk));
    assign w_free  = !r_valid && !i_fs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            o_act   <= 1'b0;
        end else begin
            o_act <= i_act;
            if (i_clear) begin
                r_valid <= 1'b0;
            end else if (i_we && (i_wr_idx == IW'(IDX))) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we && (i_wr_idx == IW'(IDX))) begin
            r_key  <= i_src;
            r_tgt  <= i_wr_tgt;
            r_size <= i_wr_size;
        end
        o_found <= i_found || w_match;
        o_ftgt  <= w_match ? r_tgt : i_ftgt;
        o_bv    <= i_bv || w_floor;
        o_bk    <= w_floor ? r_key : i_bk;
        o_btgt  <= w_floor ? r_tgt : i_btgt;
        o_bsz   <= w_floor ? r_size : i_bsz;
        o_fs    <= i_fs || w_free;
        o_fidx  <= w_free ? IW'(IDX) : i_fidx;
    end
endmodule
`default_nettype wire

### design/fit_ctrl.sv
`default_nettype none
module fit_ctrl #(
    parameter int TABLE_ENTRIES = fit_pkg::TABLE_ENTRIES_DEF,
    parameter int ADDR_BITS     = fit_pkg::ADDR_BITS_DEF,
    parameter int SIZE_BITS     = fit_pkg::SIZE_BITS_DEF,
    parameter int IW            = 8,
    parameter int CW            = 9
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [1:0]           i_action,
    input  wire logic [ADDR_BITS-1:0] i_source_address,
    input  wire logic [ADDR_BITS-1:0] i_target_address,
    input  wire logic [SIZE_BITS-1:0] i_object_size,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [2:0]                o_status,
    output logic                      o_hit,
    output logic [ADDR_BITS-1:0]      o_result_address,
    output logic [SIZE_BITS-1:0]      o_offset_out,
    output logic [CW-1:0]             o_entry_count,
    output logic                      o_launch,
    output logic [ADDR_BITS-1:0]      o_src,
    output logic [ADDR_BITS-1:0]      o_wr_tgt,
    output logic [SIZE_BITS-1:0]      o_wr_size,
    output logic                      o_we,
    output logic [IW-1:0]             o_wr_idx,
    output logic                      o_clear,
    input  wire logic                 i_act,
    input  wire logic                 i_found,
    input  wire logic [ADDR_BITS-1:0] i_ftgt,
    input  wire logic                 i_bv,
    input  wire logic [ADDR_BITS-1:0] i_bk,
    input  wire logic [ADDR_BITS-1:0] i_btgt,
    input  wire logic [SIZE_BITS-1:0] i_bsz,
    input  wire logic                 i_fs,
    input  wire logic [IW-1:0]        i_fidx
);
    localparam int DW = (ADDR_BITS > SIZE_BITS) ? ADDR_BITS : SIZE_BITS;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state               r_state;
    logic [1:0]           r_action;
    logic [CW-1:0]        r_count;
    logic                 r_found;
    logic [ADDR_BITS-1:0] r_ftgt;
    logic                 r_bv;
    logic [ADDR_BITS-1:0] r_bk;
    logic [ADDR_BITS-1:0] r_btgt;
    logic [SIZE_BITS-1:0] r_bsz;
    logic                 r_fs;
    logic [IW-1:0]        r_fidx;
    logic                 w_accept;
    logic                 w_load;
    logic [ADDR_BITS-1:0] w_d;
    logic                 w_inside;
    logic [2:0]           n_status;
    logic                 n_hit;
    logic [ADDR_BITS-1:0] n_res;
    logic [SIZE_BITS-1:0] n_off;
    logic [CW-1:0]        n_count;
    logic                 n_we;
    logic                 n_clear;

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;
    assign w_load   = (r_state == S_FIN) && (!o_valid || i_ready);
    assign o_we     = w_load && n_we;
    assign o_clear  = w_load && n_clear;
    assign o_wr_idx = r_fidx;
    assign w_d      = o_src - r_bk;
    assign w_inside = (o_src > r_bk) && (DW'(w_d) < DW'(r_bsz));

    always_comb begin
        n_status = fit_pkg::ST_MISS;
        n_hit    = 1'b0;
        n_res    = '0;
        n_off    = '0;
        n_count  = r_count;
        n_we     = 1'b0;
        n_clear  = 1'b0;
        case (r_action)
            fit_pkg::ACT_RECORD: begin
                if ((o_src == '0) || (o_wr_tgt == '0) || (o_src == o_wr_tgt)) begin
                    n_status = fit_pkg::ST_IGNORED;
                end else if (r_found) begin
                    n_status = (r_ftgt == o_wr_tgt) ? fit_pkg::ST_DUP_SAME
                                                    : fit_pkg::ST_REJECTED;
                end else if (r_fs) begin
                    n_status = fit_pkg::ST_INSERTED;
                    n_we     = 1'b1;
                    n_count  = r_count + 1'b1;
                end else begin
                    n_status = fit_pkg::ST_FULL;
                end
            end
            fit_pkg::ACT_EXACT: begin
                if ((o_src != '0) && r_found) begin
                    n_status = fit_pkg::ST_HIT;
                    n_hit    = 1'b1;
                    n_res    = r_ftgt;
                end
            end
            fit_pkg::ACT_CONTAIN: begin
                if ((o_src != '0) && r_bv && w_inside) begin
                    n_status = fit_pkg::ST_HIT;
                    n_hit    = 1'b1;
                    n_res    = r_btgt + w_d;
                    n_off    = SIZE_BITS'(w_d);
                end
            end
            default: begin
                n_status = fit_pkg::ST_CLEARED;
                n_clear  = 1'b1;
                n_count  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            o_launch <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            o_launch <= w_accept;
            if (w_load) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (i_act) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                        r_count <= n_count;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action  <= i_action;
            o_src     <= i_source_address;
            o_wr_tgt  <= i_target_address;
            o_wr_size <= i_object_size;
        end
        if (i_act) begin
            r_found <= i_found;
            r_ftgt  <= i_ftgt;
            r_bv    <= i_bv;
            r_bk    <= i_bk;
            r_btgt  <= i_btgt;
            r_bsz   <= i_bsz;
            r_fs    <= i_fs;
            r_fidx  <= i_fidx;
        end
        if (w_load) begin
            o_status         <= n_status;
            o_hit            <= n_hit;
            o_result_address <= n_res;
            o_offset_out     <= n_off;
            o_entry_count    <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_ENTRIES)) else $error("entry count beyond table size");
    a_end_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_act |-> (r_state == S_WALK)) else $error("chain result outside walk");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_state == S_IDLE) && o_valid) else $error("result not presented");
    a_no_insert_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_we |-> (r_count < CW'(TABLE_ENTRIES))) else $error("insert into full table");
endmodule
`default_nettype wire

### test/testbench.sv
`timescale 1ns / 1ps
module testbench;
    localparam int ENTRIES    = fit_pkg::TABLE_ENTRIES_DEF;
    localparam int WATCH_MAX  = 20000;
    localparam int POOL       = 48;
    localparam logic [47:0] AMAX = 48'hFFFF_FFFF_FFFF;

    typedef struct {
        logic [1:0]  act;
        logic [47:0] src;
        logic [47:0] dst;
        logic [31:0] sz;
        bit          drain;
        bit          calm;
    } t_req;

    typedef struct {
        logic [2:0]  status;
        logic        hit;
        logic [47:0] addr;
        logic [31:0] off;
        logic [8:0]  cnt;
    } t_resp;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_ready;
    logic [1:0]  i_action = fit_pkg::ACT_RECORD;
    logic [47:0] i_source_address = '0;
    logic [47:0] i_target_address = '0;
    logic [31:0] i_object_size = '0;
    logic        o_valid;
    logic        i_ready = 0;
    logic [2:0]  o_status;
    logic        o_hit;
    logic [47:0] o_result_address;
    logic [31:0] o_offset_out;
    logic [8:0]  o_entry_count;

    forwarding_interval_table dut (.*);

    always #2 i_clk = ~i_clk;

    t_req  pending_beats[$];
    t_resp expected_resps[$];
    bit    calm_now = 0;
    int    mismatches = 0;
    int    send_gap = 0;
    int    recv_gap = 0;
    int    quiet_cycles = 0;

    // shadow of the forwarding table
    bit          fw_valid[ENTRIES];
    logic [47:0] fw_key[ENTRIES];
    logic [47:0] fw_target[ENTRIES];
    logic [31:0] fw_size[ENTRIES];
    int          fw_count = 0;

    logic [47:0] pool_key[POOL];
    logic [47:0] pool_target[POOL];
    logic [31:0] pool_size[POOL];

    function automatic t_resp forward_predict(t_req b);
        t_resp r;
        int idx;
        logic [47:0] d;
        r = '{fit_pkg::ST_MISS, 1'b0, 48'd0, 32'd0, 9'd0};
        idx = -1;
        if (b.act == fit_pkg::ACT_RECORD || b.act == fit_pkg::ACT_EXACT) begin
            for (int i = 0; i < ENTRIES; i++)
                if (idx < 0 && fw_valid[i] && fw_key[i] == b.src) idx = i;
        end
        case (b.act)
            fit_pkg::ACT_RECORD: begin
                if (b.src == 0 || b.dst == 0 || b.src == b.dst) begin
                    r.status = fit_pkg::ST_IGNORED;
                end else if (idx >= 0) begin
                    r.status = (fw_target[idx] == b.dst) ? fit_pkg::ST_DUP_SAME
                                                         : fit_pkg::ST_REJECTED;
                end else begin
                    r.status = fit_pkg::ST_FULL;
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (r.status == fit_pkg::ST_FULL && !fw_valid[i]) begin
                            fw_valid[i] = 1;
                            fw_key[i] = b.src;
                            fw_target[i] = b.dst;
                            fw_size[i] = b.sz;
                            fw_count++;
                            r.status = fit_pkg::ST_INSERTED;
                        end
                    end
                end
            end
            fit_pkg::ACT_EXACT: begin
                if (b.src != 0 && idx >= 0) begin
                    r.status = fit_pkg::ST_HIT;
                    r.hit = 1;
                    r.addr = fw_target[idx];
                end
            end
            fit_pkg::ACT_CONTAIN: begin
                for (int i = 0; i < ENTRIES; i++)
                    if (fw_valid[i] && fw_key[i] <= b.src &&
                        (idx < 0 || fw_key[i] > fw_key[idx]))
                        idx = i;
                if (b.src != 0 && idx >= 0) begin
                    d = b.src - fw_key[idx];
                    if (b.src > fw_key[idx] && d < {16'd0, fw_size[idx]}) begin
                        r.status = fit_pkg::ST_HIT;
                        r.hit = 1;
                        r.off = d[31:0];
                        r.addr = fw_target[idx] + d;
                    end
                end
            end
            default: begin
                for (int i = 0; i < ENTRIES; i++) fw_valid[i] = 0;
                fw_count = 0;
                r.status = fit_pkg::ST_CLEARED;
            end
        endcase
        r.cnt = fw_count[8:0];
        return r;
    endfunction

    function automatic logic [47:0] rand48();
        return 48'({$urandom, $urandom});
    endfunction

    task automatic push_beat(logic [1:0] act, logic [47:0] src, logic [47:0] dst,
                             logic [31:0] sz, bit drain = 0, bit calm = 0);
        pending_beats.push_back('{act, src, dst, sz, drain, calm});
    endtask

    task automatic push_random(bit calm);
        int r;
        int k;
        logic [47:0] s;
        logic [47:0] t;
        r = $urandom_range(0, 99);
        k = $urandom_range(0, POOL - 1);
        s = pool_key[k];
        t = pool_target[k];
        if (r < 40) begin
            if (r < 4) t = 0;
            else if (r < 7) t = s;
            else if (r < 10) s = 0;
            else if (r < 14) t = rand48();
            push_beat(fit_pkg::ACT_RECORD, s, t, pool_size[k], 0, calm);
        end else if (r < 58) begin
            push_beat(fit_pkg::ACT_EXACT, (r < 54) ? s : rand48(), rand48(), $urandom, 0,
                      calm);
        end else if (r < 88) begin
            s = s + $urandom_range(0, pool_size[k] > 40 ? 40 : pool_size[k] + 1);
            if (r > 84) s = pool_key[k] + pool_size[k] - $urandom_range(0, 1);
            push_beat(fit_pkg::ACT_CONTAIN, s, rand48(), $urandom, 0, calm);
        end else if (r < 90) begin
            push_beat(fit_pkg::ACT_CLEAR, rand48(), rand48(), $urandom, 0, calm);
        end else begin
            push_beat(2'($urandom_range(0, 3)), rand48(), rand48(), $urandom, 0, calm);
        end
    endtask

    // sender
    always @(posedge i_clk) begin
        t_req b;
        if (!i_rst_n) begin
            i_valid <= 0;
        end else if (!i_valid || o_ready) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_valid <= 0;
            end else if (pending_beats.size() > 0 && !(pending_beats[0].drain &&
                         (expected_resps.size() > 0 || (i_valid && o_ready)))) begin
                b = pending_beats[0];
                calm_now <= b.calm;
                if (!b.calm && $urandom_range(0, 5) == 0) begin
                    send_gap <= $urandom_range(0, 3);
                    i_valid <= 0;
                end else begin
                    void'(pending_beats.pop_front());
                    i_valid <= 1;
                    i_action <= b.act;
                    i_source_address <= b.src;
                    i_target_address <= b.dst;
                    i_object_size <= b.sz;
                end
            end else begin
                i_valid <= 0;
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        t_resp e;
        if (i_rst_n && i_valid && o_ready)
            expected_resps.push_back(forward_predict('{i_action, i_source_address,
                i_target_address, i_object_size, 1'b0, 1'b0}));
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_resps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat status=%0d", o_status);
            end else begin
                e = expected_resps.pop_front();
                if (o_status !== e.status || o_hit !== e.hit || o_result_address !== e.addr ||
                    o_offset_out !== e.off || o_entry_count !== e.cnt) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp st=%0d hit=%0d addr=%h off=%h cnt=%0d,",
                                  " got st=%0d hit=%0d addr=%h off=%h cnt=%0d"},
                                 e.status, e.hit, e.addr, e.off, e.cnt, o_status, o_hit,
                                 o_result_address, o_offset_out, o_entry_count);
                end
            end
        end
        if (!i_rst_n) begin
            i_ready <= 0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            i_ready <= 0;
        end else if (!calm_now && $urandom_range(0, 5) == 0) begin
            recv_gap <= $urandom_range(0, 3);
            i_ready <= 0;
        end else begin
            i_ready <= 1;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCH_MAX) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        for (int i = 0; i < ENTRIES; i++) fw_valid[i] = 0;
        for (int i = 0; i < POOL; i++) begin
            pool_key[i] = (i < 4) ? AMAX - 48'(i * 64)
                                  : 48'h1000 + 48'(i * 48) + 48'(i % 3);
            if (i % 7 == 0) pool_key[i] = rand48();
            pool_target[i] = (i % 5 == 0) ? AMAX - 48'(i) : rand48() | 48'd1;
            pool_size[i] = (i % 11 == 0) ? 32'd0
                         : ((i % 13 == 0) ? $urandom : $urandom_range(1, 64));
        end

        // directed corners
        push_beat(fit_pkg::ACT_RECORD, 48'd1, AMAX, 32'hFFFF_FFFF);
        push_beat(fit_pkg::ACT_RECORD, AMAX, 48'd1, 32'd16);
        push_beat(fit_pkg::ACT_RECORD, 48'd1, AMAX, 32'd4);
        push_beat(fit_pkg::ACT_RECORD, 48'd1, 48'd5, 32'd4);
        push_beat(fit_pkg::ACT_RECORD, 48'd0, 48'd9, 32'd4);
        push_beat(fit_pkg::ACT_RECORD, 48'd9, 48'd0, 32'd4);
        push_beat(fit_pkg::ACT_RECORD, 48'd9, 48'd9, 32'd4);
        push_beat(fit_pkg::ACT_RECORD, 48'd100, AMAX - 1, 32'd10);
        push_beat(fit_pkg::ACT_RECORD, 48'd200, 48'd300, 32'd0);
        push_beat(fit_pkg::ACT_EXACT, 48'd100, '0, '0);
        push_beat(fit_pkg::ACT_EXACT, 48'd101, '0, '0);
        push_beat(fit_pkg::ACT_EXACT, 48'd0, AMAX, 32'hFFFF_FFFF);
        push_beat(fit_pkg::ACT_CONTAIN, 48'd100, '0, '0);
        push_beat(fit_pkg::ACT_CONTAIN, 48'd101, '0, '0);
        push_beat(fit_pkg::ACT_CONTAIN, 48'd105, '0, '0);
        push_beat(fit_pkg::ACT_CONTAIN, 48'd110, '0, '0);
        push_beat(fit_pkg::ACT_CONTAIN, 48'd201, '0, '0);
        push_beat(fit_pkg::ACT_CONTAIN, 48'd50, '0, '0);
        push_beat(fit_pkg::ACT_CONTAIN, 48'd0, '0, '0);
        push_beat(fit_pkg::ACT_CONTAIN, AMAX, '0, '0);
        push_beat(fit_pkg::ACT_CONTAIN, 48'd1000, '0, '0);
        push_beat(fit_pkg::ACT_CLEAR, AMAX, AMAX, 32'hFFFF_FFFF);
        push_beat(fit_pkg::ACT_EXACT, 48'd100, '0, '0);

        for (int i = 0; i < 1300; i++) push_random(0);

        // fill the table past capacity, then wait for the table to settle
        push_beat(fit_pkg::ACT_CLEAR, '0, '0, '0);
        for (int i = 0; i < ENTRIES + 3; i++)
            push_beat(fit_pkg::ACT_RECORD, 48'h8000 + 48'(i * 16), rand48() | 48'h10_0000,
                      32'd8);
        push_beat(fit_pkg::ACT_RECORD, 48'h8000, 48'd7, 32'd8, 1);
        for (int i = 0; i < 20; i++)
            push_beat(fit_pkg::ACT_CONTAIN, 48'h8000 + 48'($urandom_range(0, 4200)), '0, '0);
        push_beat(fit_pkg::ACT_EXACT, 48'h8010, '0, '0);
        push_beat(fit_pkg::ACT_CLEAR, '0, '0, '0);

        for (int i = 0; i < 150; i++) push_random(1);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        while (pending_beats.size() > 0 || i_valid || expected_resps.size() > 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (mismatches == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end
endmodule

### files.f
design/fit_pkg.sv
design/fit_cell.sv
design/fit_ctrl.sv
design/forwarding_interval_table.sv
test/testbench.sv
